### hdl/pdka_pkg.sv
// ----------------------------------------------------------------------------
// pdka_pkg
// Shared types, codes and constants of the per-device key auto-repeat unit.
// ----------------------------------------------------------------------------
package pdka_pkg;

    // slot count and field widths
    localparam int DEVICE_SLOTS = 16;
    localparam int SLOT_W       = 4;
    localparam int ACTION_W     = 3;
    localparam int KEY_ACT_W    = 2;
    localparam int SYM_W        = 32;
    localparam int SCAN_W       = 16;
    localparam int MODS_W       = 16;
    localparam int TICKS_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // configuration reset values
    localparam logic [TICKS_W-1:0] INITIAL_DELAY_RST   = 16'd500;
    localparam logic [TICKS_W-1:0] REPEAT_INTERVAL_RST = 16'd50;

    // xkb keysyms of modifier and lock keys
    localparam logic [SYM_W-1:0] KSYM_SHIFT_L     = 32'h0000_FFE1;
    localparam logic [SYM_W-1:0] KSYM_HYPER_R     = 32'h0000_FFEE;
    localparam logic [SYM_W-1:0] KSYM_CAPS_LOCK   = 32'h0000_FFE5;
    localparam logic [SYM_W-1:0] KSYM_SCROLL_LOCK = 32'h0000_FF14;
    localparam logic [SYM_W-1:0] KSYM_NUM_LOCK    = 32'h0000_FF7F;
    localparam logic [SYM_W-1:0] KSYM_SUPER_R     = 32'h0000_FFEC;

    typedef enum logic [ACTION_W-1:0] {
        ACT_KEY       = 3'd0,
        ACT_TICK      = 3'd1,
        ACT_REMOVE    = 3'd2,
        ACT_TOUCH_ADD = 3'd3,
        ACT_CLEAR     = 3'd4
    } t_action;

    typedef enum logic [KEY_ACT_W-1:0] {
        KEY_UP     = 2'd0,
        KEY_DOWN   = 2'd1,
        KEY_REPEAT = 2'd2,
        KEY_MODS   = 2'd3
    } t_key_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_ON       = 2'd0,
        CFG_INITIAL_DELAY   = 2'd1,
        CFG_REPEAT_INTERVAL = 2'd2,
        CFG_SKIP_TOUCH      = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic exec_item;   // apply an accepted non-tick beat
        logic tick_start;  // snapshot expiring slots, rewind scan index
        logic step;        // process the slot under the scan index
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic step_done;   // current slot finished this cycle
        logic last_slot;   // scan index sits on the final slot
    } t_dp_status;

    // modifier and lock keys never auto-repeat
    // caps lock and super_r lie inside the shift_l..hyper_r span
    function automatic logic is_modifier_key(input logic [SYM_W-1:0] sym);
        return (sym == KSYM_SCROLL_LOCK) || (sym == KSYM_NUM_LOCK) ||
               ((sym >= KSYM_SHIFT_L) && (sym <= KSYM_HYPER_R));
    endfunction

endpackage

### hdl/per_device_key_autorepeat_unit.sv
// ----------------------------------------------------------------------------
// per_device_key_autorepeat_unit
// Per-device keyboard auto-repeat timers with one repeat beat per expiry.
// ----------------------------------------------------------------------------
// Key, removal, touch-registration and clear-all beats take effect in the
// cycle they are accepted, and ready stays high after them. A tick beat walks
// the sixteen device slots one per cycle, pausing on an expiring slot while
// the result register is full, and holds ready low until the walk ends;
// results leave in ascending slot order through a single output register,
// the final one of a tick flagged with last_of_tick. There is no clearing
// pass after reset; slot contents are only read once armed.
// ----------------------------------------------------------------------------
module per_device_key_autorepeat_unit
    import pdka_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [SLOT_W-1:0]     i_device_slot,
    input  logic [KEY_ACT_W-1:0]  i_key_action,
    input  logic [SYM_W-1:0]      i_key_symbol,
    input  logic [SCAN_W-1:0]     i_scan_code,
    input  logic [MODS_W-1:0]     i_modifier_bits,
    // repeat beats
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SLOT_W-1:0]     o_repeat_slot,
    output logic [SYM_W-1:0]      o_repeat_symbol,
    output logic [SCAN_W-1:0]     o_repeat_scan,
    output logic [MODS_W-1:0]     o_repeat_modifiers,
    output logic                  o_last_of_tick
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    pdka_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // slot state and result register
    pdka_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_action           (i_action),
        .i_device_slot      (i_device_slot),
        .i_key_action       (i_key_action),
        .i_key_symbol       (i_key_symbol),
        .i_scan_code        (i_scan_code),
        .i_modifier_bits    (i_modifier_bits),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_repeat_slot      (o_repeat_slot),
        .o_repeat_symbol    (o_repeat_symbol),
        .o_repeat_scan      (o_repeat_scan),
        .o_repeat_modifiers (o_repeat_modifiers),
        .o_last_of_tick     (o_last_of_tick)
    );

endmodule

### hdl/pdka_ctrl.sv
// ----------------------------------------------------------------------------
// pdka_ctrl
// Controller: takes input beats and sequences the per-slot tick scan.
// ----------------------------------------------------------------------------
module pdka_ctrl
    import pdka_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [ACTION_W-1:0] i_action,
    output logic                o_ready,
    output t_dp_cmd             o_cmd,
    input  t_dp_status          i_status
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_tick;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign is_tick = (i_action == ACT_TICK);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_tick) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.step_done && i_status.last_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready          = 1'b0;
        o_cmd.exec_item  = 1'b0;
        o_cmd.tick_start = 1'b0;
        o_cmd.step       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.exec_item  = accept && !is_tick;
                o_cmd.tick_start = accept && is_tick;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### hdl/pdka_datapath.sv
// ----------------------------------------------------------------------------
// pdka_datapath
// Slot timers and key store, touch registration, config and result register.
// ----------------------------------------------------------------------------
module pdka_datapath
    import pdka_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input payload
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [SLOT_W-1:0]     i_device_slot,
    input  logic [KEY_ACT_W-1:0]  i_key_action,
    input  logic [SYM_W-1:0]      i_key_symbol,
    input  logic [SCAN_W-1:0]     i_scan_code,
    input  logic [MODS_W-1:0]     i_modifier_bits,
    // control
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    // result beat
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SLOT_W-1:0]     o_repeat_slot,
    output logic [SYM_W-1:0]      o_repeat_symbol,
    output logic [SCAN_W-1:0]     o_repeat_scan,
    output logic [MODS_W-1:0]     o_repeat_modifiers,
    output logic                  o_last_of_tick
);

    // configuration registers
    logic               r_repeat_on;
    logic [TICKS_W-1:0] r_initial_delay;
    logic [TICKS_W-1:0] r_repeat_interval;
    logic               r_skip_touch;

    // per-slot state
    logic [DEVICE_SLOTS-1:0] r_armed;
    logic [TICKS_W-1:0]      r_count [DEVICE_SLOTS];
    logic [SYM_W-1:0]        r_sym   [DEVICE_SLOTS];
    logic [SCAN_W-1:0]       r_scan  [DEVICE_SLOTS];
    logic [MODS_W-1:0]       r_mods  [DEVICE_SLOTS];

    logic              r_touch_valid;
    logic [SLOT_W-1:0] r_touch_slot;

    // scan state
    logic [SLOT_W-1:0]       r_idx;
    logic [DEVICE_SLOTS-1:0] r_fire_mask;

    // result register
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [SYM_W-1:0]  r_out_sym;
    logic [SCAN_W-1:0] r_out_scan;
    logic [MODS_W-1:0] r_out_mods;
    logic              r_out_last;

    t_action     act;
    t_key_action kact;
    logic        key_ok;
    logic        modifier;
    logic        do_arm;
    logic        do_disarm;
    logic        do_clear;
    logic        do_touch_add;
    logic        touch_drop;

    logic                    cur_fire;
    logic                    emit_ok;
    logic                    do_emit;
    logic                    is_last;
    logic [DEVICE_SLOTS-1:0] fire_now;

    // decode of a non-tick beat
    always_comb begin
        act          = t_action'(i_action);
        kact         = t_key_action'(i_key_action);
        modifier     = is_modifier_key(i_key_symbol);
        key_ok       = r_repeat_on &&
                       !(r_skip_touch && r_touch_valid && (i_device_slot == r_touch_slot));
        do_arm       = 1'b0;
        do_disarm    = 1'b0;
        do_clear     = 1'b0;
        do_touch_add = 1'b0;
        touch_drop   = 1'b0;
        if (i_cmd.exec_item) begin
            case (act)
                ACT_KEY: begin
                    if (key_ok) begin
                        do_arm    = (kact == KEY_DOWN) && !modifier;
                        do_disarm = (kact == KEY_UP) || ((kact == KEY_DOWN) && modifier);
                    end
                end
                ACT_REMOVE: begin
                    do_disarm  = 1'b1;
                    touch_drop = r_touch_valid && (r_touch_slot == i_device_slot);
                end
                ACT_TOUCH_ADD: do_touch_add = 1'b1;
                ACT_CLEAR:     do_clear     = 1'b1;
                default: ;
            endcase
        end
    end

    // expiry of the slot under scan and of all slots at tick start
    always_comb begin
        for (int i = 0; i < DEVICE_SLOTS; i++) begin
            fire_now[i] = r_armed[i] && (r_count[i] <= TICKS_W'(1));
        end
        cur_fire = fire_now[r_idx];
        emit_ok  = !r_out_valid || i_ready;
        do_emit  = i_cmd.step && cur_fire && emit_ok;
        is_last  = ((r_fire_mask >> r_idx) >> 1) == '0;
    end

    assign o_status.step_done = !cur_fire || emit_ok;
    assign o_status.last_slot = (r_idx == SLOT_W'(DEVICE_SLOTS - 1));

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_on       <= 1'b1;
            r_initial_delay   <= INITIAL_DELAY_RST;
            r_repeat_interval <= REPEAT_INTERVAL_RST;
            r_skip_touch      <= 1'b0;
            r_armed           <= '0;
            r_touch_valid     <= 1'b0;
            r_touch_slot      <= '0;
            r_idx             <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_REPEAT_ON:       r_repeat_on       <= i_cfg_data[0];
                    CFG_INITIAL_DELAY:   r_initial_delay   <= i_cfg_data[TICKS_W-1:0];
                    CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data[TICKS_W-1:0];
                    CFG_SKIP_TOUCH:      r_skip_touch      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (do_clear) begin
                r_armed <= '0;
            end else if (do_arm) begin
                r_armed[i_device_slot] <= 1'b1;
            end else if (do_disarm) begin
                r_armed[i_device_slot] <= 1'b0;
            end
            if (do_touch_add) begin
                r_touch_valid <= 1'b1;
                r_touch_slot  <= i_device_slot;
            end else if (touch_drop) begin
                r_touch_valid <= 1'b0;
            end
            // scan index walks one slot per finished step
            if (i_cmd.tick_start) begin
                r_idx <= '0;
            end else if (i_cmd.step && o_status.step_done) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot payload, countdowns and result data
    always_ff @(posedge i_clk) begin
        if (do_arm) begin
            r_count[i_device_slot] <= r_initial_delay;
            r_sym[i_device_slot]   <= i_key_symbol;
            r_scan[i_device_slot]  <= i_scan_code;
            r_mods[i_device_slot]  <= i_modifier_bits;
        end
        if (i_cmd.tick_start) begin
            r_fire_mask <= fire_now;
        end
        // count down, or reload on expiry once the result register is free
        if (i_cmd.step && r_armed[r_idx]) begin
            if (!cur_fire) begin
                r_count[r_idx] <= r_count[r_idx] - TICKS_W'(1);
            end else if (emit_ok) begin
                r_count[r_idx] <= r_repeat_interval;
            end
        end
        if (do_emit) begin
            r_out_slot <= r_idx;
            r_out_sym  <= r_sym[r_idx];
            r_out_scan <= r_scan[r_idx];
            r_out_mods <= r_mods[r_idx];
            r_out_last <= is_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_repeat_slot      = r_out_slot;
    assign o_repeat_symbol    = r_out_sym;
    assign o_repeat_scan      = r_out_scan;
    assign o_repeat_modifiers = r_out_mods;
    assign o_last_of_tick     = r_out_last;

endmodule

### hdl/pdka_checker.sv
// ----------------------------------------------------------------------------
// pdka_checker
// Port-level checks of the auto-repeat unit, bound to the top level.
// ----------------------------------------------------------------------------
module pdka_checker
    import pdka_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [ACTION_W-1:0] i_action,
    input logic                o_valid,
    input logic                i_ready,
    input logic [SYM_W-1:0]    o_repeat_symbol,
    input logic                o_last_of_tick
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_repeat_symbol) &&
                                   $stable(o_last_of_tick)))
        else $error("result beat changed while stalled");

    // a tick starts a scan, so the input side closes
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action == ACT_TICK)) |=> !o_ready)
        else $error("input accepted right after a tick");

    // other beats keep the input side open
    a_item_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action != ACT_TICK)) |=> o_ready)
        else $error("non-tick beat stalled the input");

    // reset leaves the unit empty and open for input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("unit not idle after reset");

endmodule

bind per_device_key_autorepeat_unit pdka_checker u_pdka_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_action        (i_action),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_repeat_symbol (o_repeat_symbol),
    .o_last_of_tick  (o_last_of_tick)
);
